// ----- design/cpsl_pkg.sv -----
// Shared types, codes and widths of the connection pool slot lender.
package cpsl_pkg;

    localparam int DEF_ENTRIES = 32;

    localparam int OP_W   = 3;
    localparam int SLOT_W = 5;
    localparam int PID_W  = 31;
    localparam int KEY_W  = 32;
    localparam int MAJ_W  = 4;
    localparam int TIME_W = 32;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 6;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = KIND_W + STAT_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    localparam logic [OP_W-1:0] OP_LEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
    localparam logic [OP_W-1:0] OP_DIED    = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd3;
    localparam logic [OP_W-1:0] OP_MARK    = 3'd4;

    localparam logic [1:0] ST_EMPTY     = 2'd0;
    localparam logic [1:0] ST_LOADED    = 2'd1;
    localparam logic [1:0] ST_CONNECTED = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READY   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RECYCLE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NO_SLOT = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_OWNER = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NONE      = 2'd3;

    typedef struct packed {
        logic [1:0]        status;
        logic              leased;
        logic [PID_W-1:0]  owner;
        logic              cleanup;
        logic [MAJ_W-1:0]  major;
        logic [KEY_W-1:0]  user;
        logic [KEY_W-1:0]  database;
        logic [TIME_W-1:0] ret_time;
    } entry_t;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [KEY_W-1:0] user;
        logic [KEY_W-1:0] database;
        logic [MAJ_W-1:0] major;
        logic             is_lend;
    } scan_req_t;

    typedef struct packed {
        logic              found;
        logic [KIND_W-1:0] kind;
    } scan_res_t;

endpackage

// ----- design/connection_pool_slot_lender_core.sv -----
// Connection pool slot lender top level: control sequencer around the entry table.
//
//  channel  | signals                           | word
//  ---------+-----------------------------------+------------------------------------
//  cfg      | cfg_valid/ready, cfg_data[5:0]    | entries_in_use
//  s_axis   | tvalid/tready, tdata[143:0], tuser | request: op in tuser
//  m_axis   | tvalid/tready, tdata[7:0], tuser  | granted_slot; lease_kind, status
//
// Lend and owner died: the n active entries get one table read per cycle through
// the single read port; the scan drains and decides, then the chosen entry is
// read, modified and written back. Release, load, mark connected: read, modify
// and write-back of the slot; out of range or unknown op: straight to output.
// After reset a clearing pass writes all ENTRIES entries, one per cycle. A word
// is taken only in idle, after that pass; a stalled output holds the sequencer.
module connection_pool_slot_lender_core
    import cpsl_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pool_slot, requester_pid, user_key, database_key, proto_major,
    // discard, mark_cleanup, now
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // granted_slot
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // lease_kind, status
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CFG_W-1:0]  cfg_reg;
    logic [CW-1:0]     iss_reg, iss_next;
    logic              pend_reg, pend_next;
    logic [IW-1:0]     pidx_reg, pidx_next;
    logic [IW-1:0]     tgt_reg, tgt_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [SLOT_W-1:0] gslot_reg, gslot_next;
    logic              mvalid_reg, mvalid_next;
    logic [SLOT_W-1:0] mslot_reg, mslot_next;
    logic [KIND_W-1:0] mkind_reg, mkind_next;
    logic [STAT_W-1:0] mstat_reg, mstat_next;

    logic [OP_W-1:0]   op_reg;
    logic              disc_reg;
    logic              mark_reg;
    logic [TIME_W-1:0] now_reg;
    scan_req_t         req_reg;

    logic [CW-1:0]     n_cnt;
    logic              in_acc;
    logic [SLOT_W-1:0] in_slot;
    logic              in_slot_ok;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    entry_t            ram_rdata;
    scan_res_t         scan_res;
    logic [IW-1:0]     scan_idx;
    entry_t            mod_e;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = state_reg == S_IDLE;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_slot       = s_axis_tdata[4:0];
    assign n_cnt = (CW'(cfg_reg) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cfg_reg);
    assign in_slot_ok    = CW'(in_slot) < n_cnt;

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(mslot_reg);
    assign m_axis_tuser  = {mstat_reg, mkind_reg};

    cpsl_entry_ram #(.ENTRIES(ENTRIES), .IW(IW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cpsl_scan #(.ENTRIES(ENTRIES), .IW(IW)) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_acc),
        .req     (req_reg),
        .ent_vld (pend_reg && state_reg == S_SCAN),
        .ent_idx (pidx_reg),
        .ent     (ram_rdata),
        .res     (scan_res),
        .sel_idx (scan_idx)
    );

    // read-modify-write of the target entry
    always_comb
    begin
        mod_e = ram_rdata;
        unique case (op_reg)
            OP_LEND:
            begin
                mod_e.leased = 1'b1;
                mod_e.owner  = req_reg.pid;
            end
            OP_RELEASE:
            begin
                if (disc_reg)
                begin
                    mod_e.status   = ST_EMPTY;
                    mod_e.user     = '0;
                    mod_e.database = '0;
                    mod_e.major    = '0;
                end
                else
                begin
                    mod_e.cleanup = mark_reg;
                end
                mod_e.leased = 1'b0;
                mod_e.owner  = '0;
            end
            OP_DIED:
            begin
                mod_e.leased   = 1'b0;
                mod_e.owner    = '0;
                mod_e.cleanup  = 1'b1;
                mod_e.status   = ST_EMPTY;
                mod_e.ret_time = now_reg;
                mod_e.user     = '0;
                mod_e.database = '0;
                mod_e.major    = '0;
            end
            OP_LOAD:
            begin
                mod_e.user     = req_reg.user;
                mod_e.database = req_reg.database;
                mod_e.major    = req_reg.major;
                mod_e.status   = ST_LOADED;
            end
            OP_MARK:
            begin
                mod_e.status = ST_CONNECTED;
            end
            default:
            begin
                mod_e = ram_rdata;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        iss_next    = iss_reg;
        pend_next   = 1'b0;
        pidx_next   = pidx_reg;
        tgt_next    = tgt_reg;
        kind_next   = kind_reg;
        stat_next   = stat_reg;
        gslot_next  = gslot_reg;
        mvalid_next = mvalid_reg && !m_axis_tready;
        mslot_next  = mslot_reg;
        mkind_next  = mkind_reg;
        mstat_next  = mstat_reg;
        ram_we      = 1'b0;
        ram_waddr   = tgt_reg;
        ram_wdata   = mod_e;
        ram_re      = 1'b0;
        ram_raddr   = tgt_reg;
        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = iss_reg[IW-1:0];
                ram_wdata = '0;
                iss_next  = iss_reg + 1'b1;
                if (iss_reg[IW-1:0] == IW'(ENTRIES - 1))
                begin
                    iss_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    iss_next   = '0;
                    kind_next  = KIND_NONE;
                    stat_next  = STAT_OK;
                    gslot_next = '0;
                    tgt_next   = IW'(in_slot);
                    if (s_axis_tuser == OP_LEND || s_axis_tuser == OP_DIED)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (s_axis_tuser == OP_RELEASE || s_axis_tuser == OP_LOAD
                             || s_axis_tuser == OP_MARK)
                    begin
                        if (in_slot_ok)
                        begin
                            state_next = S_RD;
                        end
                        else
                        begin
                            stat_next  = STAT_RANGE;
                            state_next = S_OUT;
                        end
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_SCAN:
            begin
                if (iss_reg < n_cnt)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = iss_reg[IW-1:0];
                    pidx_next = iss_reg[IW-1:0];
                    pend_next = 1'b1;
                    iss_next  = iss_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    if (scan_res.found)
                    begin
                        tgt_next   = scan_idx;
                        kind_next  = scan_res.kind;
                        gslot_next = req_reg.is_lend ? SLOT_W'(scan_idx) : '0;
                        state_next = S_RD;
                    end
                    else
                    begin
                        kind_next  = req_reg.is_lend ? KIND_NO_SLOT : KIND_NONE;
                        stat_next  = STAT_NONE;
                        state_next = S_OUT;
                    end
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (op_reg == OP_RELEASE
                    && (!ram_rdata.leased || ram_rdata.owner != req_reg.pid))
                begin
                    stat_next = STAT_NOT_OWNER;
                end
                else
                begin
                    ram_we = 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!mvalid_reg || m_axis_tready)
                begin
                    mvalid_next = 1'b1;
                    mslot_next  = gslot_reg;
                    mkind_next  = kind_reg;
                    mstat_next  = stat_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            cfg_reg    <= CFG_RESET;
            iss_reg    <= '0;
            pend_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            iss_reg    <= iss_next;
            pend_reg   <= pend_next;
            mvalid_reg <= mvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        tgt_reg   <= tgt_next;
        kind_reg  <= kind_next;
        stat_reg  <= stat_next;
        gslot_reg <= gslot_next;
        mslot_reg <= mslot_next;
        mkind_reg <= mkind_next;
        mstat_reg <= mstat_next;
        if (in_acc)
        begin
            op_reg           <= s_axis_tuser;
            req_reg.pid      <= s_axis_tdata[35:5];
            req_reg.user     <= s_axis_tdata[67:36];
            req_reg.database <= s_axis_tdata[99:68];
            req_reg.major    <= s_axis_tdata[103:100];
            req_reg.is_lend  <= s_axis_tuser == OP_LEND;
            disc_reg         <= s_axis_tdata[104];
            mark_reg         <= s_axis_tdata[105];
            now_reg          <= s_axis_tdata[137:106];
        end
    end

endmodule

// ----- design/cpsl_entry_ram.sv -----
// Entry table: one write port, one registered read port.
module cpsl_entry_ram
    import cpsl_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int IW = $clog2(ENTRIES)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [IW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/cpsl_scan.sv -----
// Per-entry selection for lend and owner-died scans.
module cpsl_scan
    import cpsl_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int IW = $clog2(ENTRIES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  scan_req_t     req,
    input  logic          ent_vld,
    input  logic [IW-1:0] ent_idx,
    input  entry_t        ent,
    output scan_res_t     res,
    output logic [IW-1:0] sel_idx
);

    logic              hit_reg, hit_next;
    logic              hit_cl_reg, hit_cl_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    logic              free_reg, free_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic              good_reg, good_next;
    logic              vic_reg, vic_next;
    logic [IW-1:0]     vic_idx_reg, vic_idx_next;
    logic [TIME_W-1:0] vic_time_reg, vic_time_next;
    logic              dead_reg, dead_next;
    logic [IW-1:0]     dead_idx_reg, dead_idx_next;
    logic              avail;
    logic              conn;
    logic              match;

    always_comb
    begin
        hit_next      = hit_reg;
        hit_cl_next   = hit_cl_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        good_next     = good_reg;
        vic_next      = vic_reg;
        vic_idx_next  = vic_idx_reg;
        vic_time_next = vic_time_reg;
        dead_next     = dead_reg;
        dead_idx_next = dead_idx_reg;
        avail = !ent.leased;
        conn  = ent.status == ST_CONNECTED;
        match = ent.major == req.major && ent.user == req.user
                && ent.database == req.database;
        if (start)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
            good_next = 1'b0;
            vic_next  = 1'b0;
            dead_next = 1'b0;
        end
        else if (ent_vld && req.is_lend && !hit_reg)
        begin
            if (conn && avail && match)
            begin
                hit_next     = 1'b1;
                hit_cl_next  = ent.cleanup;
                hit_idx_next = ent_idx;
            end
            else
            begin
                if (!free_reg && ent.status == ST_EMPTY && avail)
                begin
                    free_next     = 1'b1;
                    free_idx_next = ent_idx;
                end
                if (!free_reg && !good_reg && conn && avail)
                begin
                    if (ent.cleanup)
                    begin
                        vic_next     = 1'b1;
                        good_next    = 1'b1;
                        vic_idx_next = ent_idx;
                    end
                    else if (!vic_reg || ent.ret_time < vic_time_reg)
                    begin
                        vic_next      = 1'b1;
                        vic_idx_next  = ent_idx;
                        vic_time_next = ent.ret_time;
                    end
                end
            end
        end
        else if (ent_vld && !req.is_lend && !dead_reg)
        begin
            if (ent.leased && ent.owner == req.pid)
            begin
                dead_next     = 1'b1;
                dead_idx_next = ent_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            good_reg <= 1'b0;
            vic_reg  <= 1'b0;
            dead_reg <= 1'b0;
        end
        else
        begin
            hit_reg  <= hit_next;
            free_reg <= free_next;
            good_reg <= good_next;
            vic_reg  <= vic_next;
            dead_reg <= dead_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_cl_reg   <= hit_cl_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        vic_idx_reg  <= vic_idx_next;
        vic_time_reg <= vic_time_next;
        dead_idx_reg <= dead_idx_next;
    end

    always_comb
    begin
        res.found = 1'b0;
        res.kind  = KIND_NO_SLOT;
        sel_idx   = '0;
        if (!req.is_lend)
        begin
            res.found = dead_reg;
            res.kind  = KIND_NONE;
            sel_idx   = dead_idx_reg;
        end
        else if (hit_reg)
        begin
            res.found = 1'b1;
            res.kind  = hit_cl_reg ? KIND_RECYCLE : KIND_READY;
            sel_idx   = hit_idx_reg;
        end
        else if (free_reg)
        begin
            res.found = 1'b1;
            res.kind  = KIND_EMPTY;
            sel_idx   = free_idx_reg;
        end
        else if (vic_reg)
        begin
            res.found = 1'b1;
            res.kind  = KIND_RECYCLE;
            sel_idx   = vic_idx_reg;
        end
    end

endmodule

// ----- tb/sv/tb_connection_pool_slot_lender_core.sv -----
// Testbench for the connection pool slot lender: directed table, random traffic, predictor check.
module tb_connection_pool_slot_lender_core;
    import cpsl_pkg::*;

    localparam int N_ENT = 32;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [PID_W-1:0]  pid;
        logic [KEY_W-1:0]  user;
        logic [KEY_W-1:0]  db;
        logic [MAJ_W-1:0]  major;
        logic              disc;
        logic              mark;
        logic [TIME_W-1:0] now;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] stat;
    } grant_t;

    typedef struct {
        req_t   rq;
        logic   typed;
        grant_t res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [OP_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    logic [1:0]        m_status [N_ENT];
    logic              m_leased [N_ENT];
    logic [PID_W-1:0]  m_owner [N_ENT];
    logic              m_cleanup [N_ENT];
    logic [MAJ_W-1:0]  m_major [N_ENT];
    logic [KEY_W-1:0]  m_user [N_ENT];
    logic [KEY_W-1:0]  m_db [N_ENT];
    logic [TIME_W-1:0] m_ret [N_ENT];
    logic [CFG_W-1:0]  m_in_use;

    grant_t expected_grants[$];
    int errors = 0;
    int cycles = 0;

    connection_pool_slot_lender_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void pool_reset();
        m_in_use = CFG_RESET;
        for (int i = 0; i < N_ENT; i++)
        begin
            m_status[i] = ST_EMPTY; m_leased[i] = 1'b0; m_owner[i] = '0; m_cleanup[i] = 1'b0;
            m_major[i] = '0; m_user[i] = '0; m_db[i] = '0; m_ret[i] = '0;
        end
    endfunction

    function automatic void wipe_keys(int i);
        m_user[i] = '0; m_db[i] = '0; m_major[i] = '0;
    endfunction

    function automatic grant_t lend_and_update(req_t r);
        grant_t g;
        int n;
        bit hit, free_ok, vic_ok, good, avail, conn;
        int free_slot, vic_slot;
        logic [TIME_W-1:0] vic_time;
        g = '{slot: '0, kind: KIND_NONE, stat: STAT_OK};
        n = (m_in_use > N_ENT) ? N_ENT : int'(m_in_use);
        hit = 1'b0; free_ok = 1'b0; vic_ok = 1'b0; good = 1'b0;
        free_slot = 0; vic_slot = 0; vic_time = '0;
        case (r.op)
            OP_LEND:
            begin
                for (int i = 0; i < n; i++)
                begin
                    avail = !m_leased[i];
                    conn = (m_status[i] == ST_CONNECTED);
                    if (conn && avail && m_major[i] == r.major && m_user[i] == r.user
                        && m_db[i] == r.db)
                    begin
                        g.slot = SLOT_W'(i);
                        g.kind = m_cleanup[i] ? KIND_RECYCLE : KIND_READY;
                        hit = 1'b1;
                        break;
                    end
                    if (!free_ok && m_status[i] == ST_EMPTY && avail)
                    begin
                        free_ok = 1'b1; free_slot = i;
                    end
                    if (!free_ok && !good && conn && avail)
                    begin
                        if (m_cleanup[i])
                        begin
                            vic_slot = i; vic_ok = 1'b1; good = 1'b1;
                        end
                        else if (!vic_ok || m_ret[i] < vic_time)
                        begin
                            vic_time = m_ret[i]; vic_slot = i; vic_ok = 1'b1;
                        end
                    end
                end
                if (!hit)
                begin
                    if (free_ok)
                    begin
                        g.slot = SLOT_W'(free_slot); g.kind = KIND_EMPTY;
                    end
                    else if (vic_ok)
                    begin
                        g.slot = SLOT_W'(vic_slot); g.kind = KIND_RECYCLE;
                    end
                    else
                    begin
                        g.kind = KIND_NO_SLOT; g.stat = STAT_NONE;
                    end
                end
                if (g.kind != KIND_NO_SLOT)
                begin
                    m_leased[g.slot] = 1'b1; m_owner[g.slot] = r.pid;
                end
            end
            OP_RELEASE:
            begin
                if (r.slot >= n) g.stat = STAT_RANGE;
                else if (!m_leased[r.slot] || m_owner[r.slot] != r.pid) g.stat = STAT_NOT_OWNER;
                else
                begin
                    if (r.disc)
                    begin
                        m_status[r.slot] = ST_EMPTY;
                        wipe_keys(int'(r.slot));
                    end
                    else
                        m_cleanup[r.slot] = r.mark;
                    m_leased[r.slot] = 1'b0; m_owner[r.slot] = '0;
                end
            end
            OP_DIED:
            begin
                g.stat = STAT_NONE;
                for (int i = 0; i < n; i++)
                begin
                    if (m_leased[i] && m_owner[i] == r.pid)
                    begin
                        m_leased[i] = 1'b0; m_owner[i] = '0; m_cleanup[i] = 1'b1;
                        m_status[i] = ST_EMPTY; m_ret[i] = r.now;
                        wipe_keys(i);
                        g.stat = STAT_OK;
                        break;
                    end
                end
            end
            OP_LOAD:
            begin
                if (r.slot >= n) g.stat = STAT_RANGE;
                else
                begin
                    m_user[r.slot] = r.user; m_db[r.slot] = r.db;
                    m_major[r.slot] = r.major; m_status[r.slot] = ST_LOADED;
                end
            end
            OP_MARK:
            begin
                if (r.slot >= n) g.stat = STAT_RANGE;
                else m_status[r.slot] = ST_CONNECTED;
            end
            default: ;
        endcase
        return g;
    endfunction

    task automatic send_word(req_t r, logic typed, grant_t res);
        grant_t g;
        g = lend_and_update(r);
        if (typed && g != res)
        begin
            $display("%0t table row disagrees: typed %0d/%0d/%0d model %0d/%0d/%0d", $time,
                     res.slot, res.kind, res.stat, g.slot, g.kind, g.stat);
            errors++;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.op;
        s_axis_tdata <= {6'd0, r.now, r.mark, r.disc, r.major, r.db, r.user, r.pid, r.slot};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_grants.push_back(g);
        @(negedge clk);
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    task automatic write_in_use(logic [CFG_W-1:0] v);
        while (expected_grants.size() != 0) @(negedge clk);
        repeat (N_ENT + 10) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        m_in_use = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t rand_req(int pids, int keys);
        req_t r;
        int k;
        k = $urandom_range(0, 15);
        r.op = (k < 5) ? OP_LEND : (k < 8) ? OP_RELEASE : (k < 9) ? OP_DIED :
               (k < 12) ? OP_LOAD : (k < 15) ? OP_MARK : 3'($urandom_range(5, 7));
        r.slot = 5'($urandom_range(0, 31));
        r.pid = ($urandom_range(0, 9) == 0) ? 31'($urandom | 1) : 31'($urandom_range(1, pids));
        k = $urandom_range(0, keys);
        r.user = ($urandom_range(0, 19) == 0) ? $urandom : 32'(k);
        r.db = ($urandom_range(0, 19) == 0) ? $urandom : 32'(k * 3);
        r.major = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'(k & 1);
        r.disc = 1'($urandom);
        r.mark = 1'($urandom);
        r.now = $urandom;
        return r;
    endfunction

    // receiver: always ready in a repeating window, random stalls outside it
    always @(negedge clk)
    begin
        if (cycles % 97 < 40) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_grants.size() == 0)
            begin
                $display("%0t unexpected word: slot %0d kind %0d status %0d", $time,
                         m_axis_tdata[SLOT_W-1:0], m_axis_tuser[KIND_W-1:0],
                         m_axis_tuser[OUT_USER_W-1:KIND_W]);
                errors++;
            end
            else
            begin
                grant_t e;
                e = expected_grants.pop_front();
                if (m_axis_tdata != OUT_DATA_W'(e.slot))
                begin
                    $display("%0t granted_slot expected %0d actual %0d", $time, e.slot,
                             m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[KIND_W-1:0] != e.kind)
                begin
                    $display("%0t lease_kind expected %0d actual %0d", $time, e.kind,
                             m_axis_tuser[KIND_W-1:0]);
                    errors++;
                end
                if (m_axis_tuser[OUT_USER_W-1:KIND_W] != e.stat)
                begin
                    $display("%0t status expected %0d actual %0d", $time, e.stat,
                             m_axis_tuser[OUT_USER_W-1:KIND_W]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        row_t tbl[$];
        req_t r;
        grant_t none;
        int sent;
        none = '{slot: '0, kind: KIND_NONE, stat: STAT_OK};
        pool_reset();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        r = '{op: OP_LEND, slot: 0, pid: 31'h7FFFFFFF, user: '1, db: '1, major: 4'hF,
              disc: 0, mark: 0, now: '0};
        tbl.push_back('{r, 1, '{slot: 0, kind: KIND_EMPTY, stat: STAT_OK}});
        r.op = OP_RELEASE; r.pid = 1; r.slot = 0;
        tbl.push_back('{r, 1, '{slot: 0, kind: KIND_NONE, stat: STAT_NOT_OWNER}});
        r.op = OP_LOAD; r.slot = 31;
        tbl.push_back('{r, 1, none});
        r.op = OP_MARK;
        tbl.push_back('{r, 1, none});
        r.op = OP_LEND; r.pid = 5;
        tbl.push_back('{r, 0, none});
        r.op = OP_RELEASE; r.pid = 5; r.slot = 31; r.mark = 1;
        tbl.push_back('{r, 1, none});
        r.op = OP_LEND; r.pid = 6;
        tbl.push_back('{r, 0, none});
        r.op = OP_DIED; r.pid = 6; r.now = '1;
        tbl.push_back('{r, 1, none});
        r.op = OP_DIED; r.pid = 77;
        tbl.push_back('{r, 1, '{slot: 0, kind: KIND_NONE, stat: STAT_NONE}});
        r.op = OP_RELEASE; r.pid = 31'h7FFFFFFF; r.slot = 0; r.disc = 1;
        tbl.push_back('{r, 1, none});
        r.op = OP_LOAD; r.slot = 3; r.user = 0; r.db = 0; r.major = 0;
        tbl.push_back('{r, 0, none});
        r.op = 3'd5;
        tbl.push_back('{r, 1, none});
        r.op = 3'd7;
        tbl.push_back('{r, 1, none});
        foreach (tbl[i]) send_word(tbl[i].rq, tbl[i].typed, tbl[i].res);
        s_axis_tvalid <= 1'b0;

        // tiny pool: fill it, then no slot and out of range
        write_in_use(6'd1);
        r = '{op: OP_LEND, slot: 0, pid: 9, user: 0, db: 0, major: 0, disc: 0, mark: 0,
              now: 0};
        send_word(r, 0, none);
        r.pid = 10;
        send_word(r, 1, '{slot: 0, kind: KIND_NO_SLOT, stat: STAT_NONE});
        r.op = OP_LOAD; r.slot = 1;
        send_word(r, 1, '{slot: 0, kind: KIND_NONE, stat: STAT_RANGE});
        s_axis_tvalid <= 1'b0;
        write_in_use(6'd0);
        r.op = OP_LEND;
        send_word(r, 1, '{slot: 0, kind: KIND_NO_SLOT, stat: STAT_NONE});
        r.op = OP_DIED; r.pid = 9;
        send_word(r, 1, '{slot: 0, kind: KIND_NONE, stat: STAT_NONE});
        r.op = OP_MARK; r.slot = 0;
        send_word(r, 1, '{slot: 0, kind: KIND_NONE, stat: STAT_RANGE});
        s_axis_tvalid <= 1'b0;
        write_in_use(6'd63);

        sent = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            int pids, keys;
            pids = (ph % 2) ? 40 : 8;
            keys = (ph == 2) ? 30 : 4;
            while (sent < 350 * (ph + 1))
            begin
                int burst;
                burst = $urandom_range(1, 20);
                repeat (burst) send_word(rand_req(pids, keys), 0, none);
                sent += burst;
                if ($urandom_range(0, 2) != 0) idle_sender();
            end
            s_axis_tvalid <= 1'b0;
            case (ph)
                0: write_in_use(6'd32);
                1: write_in_use(6'd4);
                2: write_in_use(6'd17);
                3: write_in_use(6'($urandom_range(1, 63)));
                default: ;
            endcase
        end

        while (expected_grants.size() != 0) @(negedge clk);
        repeat (N_ENT + 20) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
